// ----- hw/rtl/biquad_df2t_filter_assert.svh -----
// Assertion macros for the biquad filter.
`ifndef BIQUAD_DF2T_FILTER_ASSERT_SVH
`define BIQUAD_DF2T_FILTER_ASSERT_SVH

// Same-cycle implication under reset
`define BQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad assertion failed");

// Next-cycle implication under reset
`define BQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad assertion failed");

`endif

// ----- hw/rtl/bq_pkg.sv -----
`timescale 1ns / 1ps

package bq_pkg;

    // Coefficient register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

    // Sequencer states, at most one product and one accumulate per step
    typedef enum logic [3:0] {
        S_IDLE,
        S_P0,
        S_A0,
        S_Y,
        S_M1,
        S_A1,
        S_N1,
        S_A2,
        S_N2
    } bq_state_t;

    // Accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    // Control from sequencer to the MAC unit
    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

endpackage

// ----- hw/rtl/bq_if.sv -----
`timescale 1ns / 1ps

// Input sample channel
interface bq_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           start_of_block;

    modport source (output valid, output sample_in, output start_of_block, input ready);
    modport sink (input valid, input sample_in, input start_of_block, output ready);
endinterface

// Output sample channel
interface bq_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

// ----- hw/rtl/bq_mac.sv -----
`timescale 1ns / 1ps

// Shared multiplier with a registered product and one accumulator
module bq_mac
    import bq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32,
    parameter int ACC_WIDTH    = 50
)
(
    input  logic                           clk,
    input  mac_ctrl_t                      ctrl,
    input  logic signed [COEF_WIDTH-1:0]   coef,
    input  logic signed [SAMPLE_WIDTH-1:0] operand,
    input  logic signed [ACC_WIDTH-1:0]    base,
    output logic signed [ACC_WIDTH-1:0]    acc
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ACC_WIDTH-1:0]  prod_ext;

    assign prod_ext = {{(ACC_WIDTH-PROD_WIDTH){prod_reg[PROD_WIDTH-1]}}, prod_reg};
    assign acc      = acc_reg;

    // Product stage
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * operand;
        end
    end

    // Accumulate stage
    always_ff @(posedge clk)
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= base + prod_ext;
            ACC_SUB:  acc_reg <= acc_reg - prod_ext;
            default:  acc_reg <= acc_reg;
        endcase
    end

endmodule

// ----- hw/rtl/biquad_df2t_filter.sv -----
`timescale 1ns / 1ps
// Biquad section, direct form II transposed, one shared multiplier.
// Each item steps through S_P0 to S_N2 in order; its result is registered at the end of S_N2.
// Five products go through the one multiplier, so one item is worked on at a time.
// A new item is taken in the last step when the output register is free.
// Reset: b0 = 1.0, other coefficients and both delay states zero, no item held.

module biquad_df2t_filter
    import bq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32,
    parameter int STATE_WIDTH  = 48
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [COEF_WIDTH-1:0]        cfg_data,
    bq_in_if.sink                        in_ch,
    bq_out_if.source                     out_ch
);

`include "biquad_df2t_filter_assert.svh"

    localparam int PROD_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int COEF_FRAC   = COEF_WIDTH - 3;
    localparam int WIDE_WIDTH  = (PROD_WIDTH > STATE_WIDTH) ? PROD_WIDTH : STATE_WIDTH;
    localparam int ACC_WIDTH   = WIDE_WIDTH + 2;
    localparam int SHIFT_WIDTH = ACC_WIDTH - COEF_FRAC;
    localparam logic [ACC_WIDTH-1:0]  HALF_LSB = ACC_WIDTH'(1) << (COEF_FRAC - 1);
    localparam logic [COEF_WIDTH-1:0] ONE_COEF = COEF_WIDTH'(1) << COEF_FRAC;

    bq_state_t state_reg, state_next;

    logic signed [COEF_WIDTH-1:0]   coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEF_WIDTH-1:0]   coef_a1_reg, coef_a2_reg;
    logic signed [STATE_WIDTH-1:0]  delay_one_reg, delay_two_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg, y_reg;
    logic                           clip_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_sat_reg;

    mac_ctrl_t                      mac_ctrl;
    logic signed [COEF_WIDTH-1:0]   mac_coef;
    logic signed [SAMPLE_WIDTH-1:0] mac_operand;
    logic signed [ACC_WIDTH-1:0]    mac_base;
    logic signed [ACC_WIDTH-1:0]    acc;

    logic                           out_free;
    logic                           accept;
    logic [SHIFT_WIDTH-1:0]         acc_shift;
    logic                           y_fit;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           st_fit;
    logic signed [STATE_WIDTH-1:0]  st_sat;
    logic signed [ACC_WIDTH-1:0]    delay_one_ext, delay_two_ext;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign accept   = in_ch.valid && in_ch.ready;

    assign delay_one_ext = {{(ACC_WIDTH-STATE_WIDTH){delay_one_reg[STATE_WIDTH-1]}},
                            delay_one_reg};
    assign delay_two_ext = {{(ACC_WIDTH-STATE_WIDTH){delay_two_reg[STATE_WIDTH-1]}},
                            delay_two_reg};

    // Output rounding: acc already holds the half LSB, drop fraction bits
    assign acc_shift = acc[ACC_WIDTH-1:COEF_FRAC];
    assign y_fit = (&acc_shift[SHIFT_WIDTH-1:SAMPLE_WIDTH-1])
                || !(|acc_shift[SHIFT_WIDTH-1:SAMPLE_WIDTH-1]);

    always_comb
    begin
        if (y_fit)
        begin
            y_sat = acc_shift[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            y_sat = {acc_shift[SHIFT_WIDTH-1], {(SAMPLE_WIDTH-1){!acc_shift[SHIFT_WIDTH-1]}}};
        end
    end

    // State saturation
    assign st_fit = (&acc[ACC_WIDTH-1:STATE_WIDTH-1]) || !(|acc[ACC_WIDTH-1:STATE_WIDTH-1]);

    always_comb
    begin
        if (st_fit)
        begin
            st_sat = acc[STATE_WIDTH-1:0];
        end
        else
        begin
            st_sat = {acc[ACC_WIDTH-1], {(STATE_WIDTH-1){!acc[ACC_WIDTH-1]}}};
        end
    end

    // Shared MAC unit
    bq_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .base    (mac_base),
        .acc     (acc)
    );

    // Sequencer: next state and datapath selects
    always_comb
    begin
        state_next      = state_reg;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = ACC_HOLD;
        mac_coef        = coef_b0_reg;
        mac_operand     = x_reg;
        mac_base        = '0;
        in_ch.ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = S_P0;
                end
            end
            S_P0:
            begin
                mac_ctrl.mul_en = 1'b1;
                state_next      = S_A0;
            end
            S_A0:
            begin
                mac_ctrl.acc_op = ACC_LOAD;
                mac_base        = delay_one_ext + $signed(HALF_LSB);
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = coef_b1_reg;
                state_next      = S_Y;
            end
            S_Y:
            begin
                mac_ctrl.acc_op = ACC_LOAD;
                mac_base        = delay_two_ext;
                state_next      = S_M1;
            end
            S_M1:
            begin
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = coef_a1_reg;
                mac_operand     = y_reg;
                state_next      = S_A1;
            end
            S_A1:
            begin
                mac_ctrl.acc_op = ACC_SUB;
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = coef_b2_reg;
                state_next      = S_N1;
            end
            S_N1:
            begin
                mac_ctrl.acc_op = ACC_LOAD;
                mac_ctrl.mul_en = 1'b1;
                mac_coef        = coef_a2_reg;
                mac_operand     = y_reg;
                state_next      = S_A2;
            end
            S_A2:
            begin
                mac_ctrl.acc_op = ACC_SUB;
                state_next      = S_N2;
            end
            S_N2:
            begin
                if (out_free)
                begin
                    in_ch.ready = 1'b1;
                    state_next  = in_ch.valid ? S_P0 : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= ONE_COEF;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_B0:  coef_b0_reg <= cfg_data;
                REG_B1:  coef_b1_reg <= cfg_data;
                REG_B2:  coef_b2_reg <= cfg_data;
                REG_A1:  coef_a1_reg <= cfg_data;
                REG_A2:  coef_a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Delay states: new z1 in S_N1, new z2 as the item closes; block start clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end
        else if (accept && in_ch.start_of_block)
        begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end
        else
        begin
            if (state_reg == S_N1)
            begin
                delay_one_reg <= st_sat;
            end
            if (state_reg == S_N2 && out_free)
            begin
                delay_two_reg <= st_sat;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_N2 && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Sample, feedback value, clip flag and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= in_ch.sample_in;
        end
        if (state_reg == S_Y)
        begin
            y_reg    <= y_sat;
            clip_reg <= !y_fit;
        end
        if (state_reg == S_N1)
        begin
            clip_reg <= clip_reg || !st_fit;
        end
        if (state_reg == S_N2 && out_free)
        begin
            out_sample_reg <= y_reg;
            out_sat_reg    <= clip_reg || !st_fit;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;
    assign out_ch.saturated  = out_sat_reg;

    // Checks
    `BQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept,
                    (state_reg == S_P0) && !in_ch.ready)
    `BQ_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_N2) && out_free,
                    out_ch.valid)
    `BQ_ASSERT_NEXT(a_block_start_clears, clk, rst_n, accept && in_ch.start_of_block,
                    (delay_one_reg == '0) && (delay_two_reg == '0))
    `BQ_ASSERT_SAME(a_ready_only_free, clk, rst_n, in_ch.ready,
                    (state_reg == S_IDLE) || ((state_reg == S_N2) && out_free))

endmodule
